// ===== hw/rtl/mkd_pkg.sv =====
`timescale 1ns / 1ps
package mkd_pkg;

  localparam int unsigned CfgW   = 32;
  localparam int unsigned FieldW = 32;
  localparam int unsigned OpW    = 49;   // multiplier operand, signed
  localparam int unsigned ProdW  = 47;   // capped product, signed
  localparam int unsigned TrigW  = 33;   // Q2.30 sine/cosine, signed
  localparam int unsigned AtanN  = 24;
  localparam int unsigned CordicGain = 32'd652032874;

  localparam logic [45:0] ProdCap = {46{1'b1}};

  typedef enum logic [1:0] {
    REG_INV_WHEEL_RADIUS = 2'd0,
    REG_HALF_SPAN        = 2'd1,
    REG_INV_MASS         = 2'd2,
    REG_INV_INERTIA      = 2'd3
  } cfg_reg_e;

  // Arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input int unsigned i);
    logic [31:0] r;
    case (i)
      0:  r = 32'd536870912;
      1:  r = 32'd316933406;
      2:  r = 32'd167458907;
      3:  r = 32'd85004756;
      4:  r = 32'd42667331;
      5:  r = 32'd21354465;
      6:  r = 32'd10679838;
      7:  r = 32'd5340245;
      8:  r = 32'd2670163;
      9:  r = 32'd1335087;
      10: r = 32'd667544;
      11: r = 32'd333772;
      12: r = 32'd166886;
      13: r = 32'd83443;
      14: r = 32'd41722;
      15: r = 32'd20861;
      16: r = 32'd10430;
      17: r = 32'd5215;
      18: r = 32'd2608;
      19: r = 32'd1304;
      20: r = 32'd652;
      21: r = 32'd326;
      22: r = 32'd163;
      23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // Clamp a capped product to the signed 32-bit range
  function automatic logic signed [FieldW-1:0] sat32(input logic signed [ProdW-1:0] v);
    logic signed [FieldW-1:0] r;
    if (v > $signed({{(ProdW-FieldW){1'b0}}, 1'b0, {(FieldW-1){1'b1}}})) begin
      r = {1'b0, {(FieldW-1){1'b1}}};
    end else if (v < $signed({{(ProdW-FieldW){1'b1}}, 1'b1, {(FieldW-1){1'b0}}})) begin
      r = {1'b1, {(FieldW-1){1'b0}}};
    end else begin
      r = v[FieldW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/mkd_delay.sv =====
`timescale 1ns / 1ps
module mkd_delay #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic [Width-1:0] d_i,
  output logic [Width-1:0] q_o
);

  logic [Width-1:0] line_q [Depth];

  always_ff @(posedge clk_i) begin
    line_q[0] <= d_i;
    for (int i = 1; i < Depth; i++) begin
      line_q[i] <= line_q[i-1];
    end
  end

  assign q_o = line_q[Depth-1];

endmodule

// ===== hw/rtl/mkd_mul.sv =====
`timescale 1ns / 1ps
// Pipelined rounding multiply: |a| clamped to 48 bits, split into two
// 24 x 32 partial products, rounded half away from zero, capped at 2^46-1.
module mkd_mul #(
  parameter int unsigned Shift = 16
) (
  input  logic                               clk_i,
  input  logic signed [mkd_pkg::OpW-1:0]     a_i,
  input  logic        [mkd_pkg::CfgW-1:0]    b_i,
  input  logic                               b_neg_i,
  output logic signed [mkd_pkg::ProdW-1:0]   p_o
);
  import mkd_pkg::*;

  localparam int unsigned FullW = 80;

  logic [OpW-1:0]   mag_full;
  logic [47:0]      mag;
  logic             neg_d, neg_q;
  logic [55:0]      pp_hi_q, pp_lo_q;
  logic [FullW-1:0] full, shifted;
  logic [45:0]      rmag;
  logic signed [ProdW-1:0] p_d, p_q;

  always_comb begin
    neg_d    = a_i[OpW-1] ^ b_neg_i;
    mag_full = a_i[OpW-1] ? OpW'(-a_i) : OpW'(a_i);
    mag      = mag_full[OpW-1] ? {48{1'b1}} : mag_full[47:0];
  end

  always_ff @(posedge clk_i) begin
    pp_hi_q <= 56'(mag[47:24]) * 56'(b_i);
    pp_lo_q <= 56'(mag[23:0]) * 56'(b_i);
    neg_q   <= neg_d;
  end

  always_comb begin
    full    = {pp_hi_q, 24'd0} + FullW'(pp_lo_q) + (FullW'(1) << (Shift - 1));
    shifted = full >> Shift;
    rmag    = (|shifted[FullW-1:46]) ? ProdCap : shifted[45:0];
    p_d     = neg_q ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

// ===== hw/rtl/mkd_cordic.sv =====
`timescale 1ns / 1ps
// Rotation-mode CORDIC, one register stage per iteration. Headings in the
// left half-plane are turned by half a turn and the results negated.
module mkd_cordic #(
  parameter int unsigned Stages = 16
) (
  input  logic                             clk_i,
  input  logic [15:0]                      heading_i,
  output logic signed [mkd_pkg::TrigW-1:0] cos_o,
  output logic signed [mkd_pkg::TrigW-1:0] sin_o
);
  import mkd_pkg::*;

  logic signed [TrigW-1:0] x_q [Stages];
  logic signed [TrigW-1:0] y_q [Stages];
  logic signed [TrigW-1:0] z_q [Stages];
  logic                    flip_q [Stages];

  logic        flip0;
  logic [31:0] ang;

  always_comb begin
    flip0 = (heading_i >= 16'd16384) && (heading_i < 16'd49152);
    ang   = {heading_i ^ {flip0, 15'd0}, 16'd0};
  end

  for (genvar i = 0; i < Stages; i++) begin : g_stage
    logic signed [TrigW-1:0] xi, yi, zi, x_d, y_d, z_d;
    logic                    fi;
    if (i == 0) begin : g_first
      assign xi = TrigW'(CordicGain);
      assign yi = '0;
      assign zi = TrigW'($signed(ang));
      assign fi = flip0;
    end else begin : g_next
      assign xi = x_q[i-1];
      assign yi = y_q[i-1];
      assign zi = z_q[i-1];
      assign fi = flip_q[i-1];
    end
    always_comb begin
      if (!zi[TrigW-1]) begin
        x_d = xi - (yi >>> i);
        y_d = yi + (xi >>> i);
        z_d = zi - $signed(TrigW'(atan_turn(i)));
      end else begin
        x_d = xi + (yi >>> i);
        y_d = yi - (xi >>> i);
        z_d = zi + $signed(TrigW'(atan_turn(i)));
      end
    end
    always_ff @(posedge clk_i) begin
      x_q[i]    <= x_d;
      y_q[i]    <= y_d;
      z_q[i]    <= z_d;
      flip_q[i] <= fi;
    end
  end

  assign cos_o = flip_q[Stages-1] ? -x_q[Stages-1] : x_q[Stages-1];
  assign sin_o = flip_q[Stages-1] ? -y_q[Stages-1] : y_q[Stages-1];

endmodule

// ===== hw/rtl/mecanum_kinematics_dynamics.sv =====
`timescale 1ns / 1ps
// Four-wheel mecanum kinematics and dynamics, fully pipelined. A word is
// taken on every cycle that start_i is high (busy_o is always low) and its
// result appears on done_o for one cycle only: the receiver cannot stall,
// so capture on done_o. The path to the outputs runs through the CORDIC (one
// register per iteration, 24 at most), then two multiplier rows, a sum
// register and the output register. Kind 0 gives wheel speeds and zero
// accelerations, kind 1 the reverse. Configuration writes take effect at
// once and must only be made while no word is in flight.
module mecanum_kinematics_dynamics #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_idx_i,
  input  logic [mkd_pkg::CfgW-1:0]            cfg_data_i,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                kind_i,
  input  logic [15:0]                         heading_i,
  input  logic signed [mkd_pkg::FieldW-1:0]   vel_x_i,
  input  logic signed [mkd_pkg::FieldW-1:0]   vel_y_i,
  input  logic signed [mkd_pkg::FieldW-1:0]   yaw_rate_i,
  input  logic signed [mkd_pkg::FieldW-1:0]   torque_front_left_i,
  input  logic signed [mkd_pkg::FieldW-1:0]   torque_front_right_i,
  input  logic signed [mkd_pkg::FieldW-1:0]   torque_back_left_i,
  input  logic signed [mkd_pkg::FieldW-1:0]   torque_back_right_i,
  output logic                                done_o,
  output logic signed [mkd_pkg::FieldW-1:0]   speed_front_left_o,
  output logic signed [mkd_pkg::FieldW-1:0]   speed_front_right_o,
  output logic signed [mkd_pkg::FieldW-1:0]   speed_back_left_o,
  output logic signed [mkd_pkg::FieldW-1:0]   speed_back_right_o,
  output logic signed [mkd_pkg::FieldW-1:0]   accel_x_o,
  output logic signed [mkd_pkg::FieldW-1:0]   accel_y_o,
  output logic signed [mkd_pkg::FieldW-1:0]   yaw_accel_o
);
  import mkd_pkg::*;

  localparam int unsigned Ns  = (CORDIC_STAGES > AtanN) ? AtanN : CORDIC_STAGES;
  localparam int unsigned Lat = Ns + 5;

  // ---- configuration registers
  logic [CfgW-1:0] inv_r_q, half_span_q, inv_mass_q, inv_inertia_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_r_q       <= 32'd1638400;
      half_span_q   <= 32'd13107;
      inv_mass_q    <= 32'd65536;
      inv_inertia_q <= 32'd65536;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_INV_WHEEL_RADIUS: inv_r_q       <= cfg_data_i;
        REG_HALF_SPAN:        half_span_q   <= cfg_data_i;
        REG_INV_MASS:         inv_mass_q    <= cfg_data_i;
        REG_INV_INERTIA:      inv_inertia_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---- valid and kind travel alongside the words
  logic [Lat-1:0] valid_q, kind_q;
  logic           accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      kind_q  <= '0;
    end else begin
      valid_q <= {valid_q[Lat-2:0], accept};
      kind_q  <= {kind_q[Lat-2:0], kind_i};
    end
  end

  // ---- front: mixing of torques, yaw moment arm, yaw rate times half span
  logic signed [OpW-1:0] t0, t1, t2, t3;
  logic signed [ProdW-1:0] m2, fx2, fy2, arm2, tz4;

  assign t0 = OpW'(torque_front_left_i);
  assign t1 = OpW'(torque_front_right_i);
  assign t2 = OpW'(torque_back_left_i);
  assign t3 = OpW'(torque_back_right_i);

  mkd_mul #(.Shift(16)) u_mul_m (
    .clk_i, .a_i(OpW'(yaw_rate_i)), .b_i(half_span_q), .b_neg_i(1'b0), .p_o(m2)
  );
  mkd_mul #(.Shift(16)) u_mul_fx (
    .clk_i, .a_i(t0 + t1 + t2 + t3), .b_i(inv_r_q), .b_neg_i(1'b0), .p_o(fx2)
  );
  mkd_mul #(.Shift(16)) u_mul_fy (
    .clk_i, .a_i(-t0 + t1 + t2 - t3), .b_i(inv_r_q), .b_neg_i(1'b0), .p_o(fy2)
  );
  mkd_mul #(.Shift(16)) u_mul_arm (
    .clk_i, .a_i(t0 - t1 + t2 - t3), .b_i(half_span_q), .b_neg_i(1'b0), .p_o(arm2)
  );
  // yaw torque is the negated product
  mkd_mul #(.Shift(16)) u_mul_tz (
    .clk_i, .a_i(OpW'(arm2)), .b_i(inv_r_q), .b_neg_i(1'b1), .p_o(tz4)
  );

  logic [FieldW-1:0] vel_x2, vel_y2;
  mkd_delay #(.Width(2*FieldW), .Depth(2)) u_dly_vel (
    .clk_i, .d_i({vel_x_i, vel_y_i}), .q_o({vel_x2, vel_y2})
  );

  // P/Q operands of the rotation: kind 0 (vy, vx), kind 1 (fx, fy)
  logic signed [ProdW-1:0] p2, q2, p4, q4, m4, r4;
  assign p2 = kind_q[1] ? fx2 : ProdW'($signed(vel_y2));
  assign q2 = kind_q[1] ? fy2 : ProdW'($signed(vel_x2));

  mkd_delay #(.Width(3*ProdW), .Depth(2)) u_dly_pqm (
    .clk_i, .d_i({p2, q2, m2}), .q_o({p4, q4, m4})
  );
  assign r4 = kind_q[3] ? tz4 : m4;

  logic signed [ProdW-1:0] pa, qa, ra, rb;
  mkd_delay #(.Width(3*ProdW), .Depth(Ns - 4)) u_dly_align (
    .clk_i, .d_i({p4, q4, r4}), .q_o({pa, qa, ra})
  );

  // ---- sine and cosine
  logic signed [TrigW-1:0] cos_v, sin_v;
  mkd_cordic #(.Stages(Ns)) u_cordic (
    .clk_i, .heading_i, .cos_o(cos_v), .sin_o(sin_v)
  );

  logic [TrigW-1:0] cos_mag, sin_mag;
  assign cos_mag = cos_v[TrigW-1] ? TrigW'(-cos_v) : TrigW'(cos_v);
  assign sin_mag = sin_v[TrigW-1] ? TrigW'(-sin_v) : TrigW'(sin_v);

  // ---- rotation products
  logic signed [ProdW-1:0] pc, qs, qc, ps;
  mkd_mul #(.Shift(30)) u_mul_pc (
    .clk_i, .a_i(OpW'(pa)), .b_i(cos_mag[31:0]), .b_neg_i(cos_v[TrigW-1]), .p_o(pc)
  );
  mkd_mul #(.Shift(30)) u_mul_qs (
    .clk_i, .a_i(OpW'(qa)), .b_i(sin_mag[31:0]), .b_neg_i(sin_v[TrigW-1]), .p_o(qs)
  );
  mkd_mul #(.Shift(30)) u_mul_qc (
    .clk_i, .a_i(OpW'(qa)), .b_i(cos_mag[31:0]), .b_neg_i(cos_v[TrigW-1]), .p_o(qc)
  );
  mkd_mul #(.Shift(30)) u_mul_ps (
    .clk_i, .a_i(OpW'(pa)), .b_i(sin_mag[31:0]), .b_neg_i(sin_v[TrigW-1]), .p_o(ps)
  );
  mkd_delay #(.Width(ProdW), .Depth(2)) u_dly_r (
    .clk_i, .d_i(ra), .q_o(rb)
  );

  // ---- sum register: bx/by mixing or world forces
  logic signed [OpW-1:0] rot_a, rot_b, rr;
  logic signed [OpW-1:0] op_d [4];
  logic signed [OpW-1:0] op_q [4];

  always_comb begin
    rot_a = OpW'(pc) - OpW'(qs);   // bx, or world x force
    rot_b = OpW'(qc) + OpW'(ps);   // by, or world y force
    rr    = OpW'(rb);
    if (kind_q[Ns+1]) begin
      op_d[0] = rot_a;
      op_d[1] = rot_b;
      op_d[2] = rr;
      op_d[3] = '0;
    end else begin
      op_d[0] = rot_b - rot_a - rr;
      op_d[1] = rot_b + rot_a + rr;
      op_d[2] = rot_b + rot_a - rr;
      op_d[3] = rot_b - rot_a + rr;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      op_q[i] <= op_d[i];
    end
  end

  // ---- final scaling
  logic kf;
  logic signed [ProdW-1:0] res [4];
  assign kf = kind_q[Ns+2];

  mkd_mul #(.Shift(16)) u_mul_f0 (
    .clk_i, .a_i(op_q[0]), .b_i(kf ? inv_mass_q : inv_r_q), .b_neg_i(1'b0), .p_o(res[0])
  );
  mkd_mul #(.Shift(16)) u_mul_f1 (
    .clk_i, .a_i(op_q[1]), .b_i(kf ? inv_mass_q : inv_r_q), .b_neg_i(1'b0), .p_o(res[1])
  );
  mkd_mul #(.Shift(16)) u_mul_f2 (
    .clk_i, .a_i(op_q[2]), .b_i(kf ? inv_inertia_q : inv_r_q), .b_neg_i(1'b0),
    .p_o(res[2])
  );
  mkd_mul #(.Shift(16)) u_mul_f3 (
    .clk_i, .a_i(op_q[3]), .b_i(inv_r_q), .b_neg_i(1'b0), .p_o(res[3])
  );

  // ---- output register; unused fields of the kind are zero
  logic done_q;
  logic signed [FieldW-1:0] sfl_q, sfr_q, sbl_q, sbr_q, ax_q, ay_q, yaw_q;
  logic ko;
  assign ko = kind_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_q[Lat-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sfl_q <= '0;
      sfr_q <= '0;
      sbl_q <= '0;
      sbr_q <= '0;
      ax_q  <= '0;
      ay_q  <= '0;
      yaw_q <= '0;
    end else if (valid_q[Lat-1]) begin
      sfl_q <= ko ? '0 : sat32(res[0]);
      sfr_q <= ko ? '0 : sat32(res[1]);
      sbl_q <= ko ? '0 : sat32(res[2]);
      sbr_q <= ko ? '0 : sat32(res[3]);
      ax_q  <= ko ? sat32(res[0]) : '0;
      ay_q  <= ko ? sat32(res[1]) : '0;
      yaw_q <= ko ? sat32(res[2]) : '0;
    end
  end

  assign done_o              = done_q;
  assign speed_front_left_o  = sfl_q;
  assign speed_front_right_o = sfr_q;
  assign speed_back_left_o   = sbl_q;
  assign speed_back_right_o  = sbr_q;
  assign accel_x_o           = ax_q;
  assign accel_y_o           = ay_q;
  assign yaw_accel_o         = yaw_q;

  // ---- assertions
  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##(Lat + 1) done_o)
    else $error("word did not complete at the fixed latency");

  a_one_kind_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((accel_x_o == 0) && (accel_y_o == 0) && (yaw_accel_o == 0)) ||
               ((speed_front_left_o == 0) && (speed_front_right_o == 0) &&
                (speed_back_left_o == 0) && (speed_back_right_o == 0)))
    else $error("both speed and acceleration fields non-zero");

  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!done_o && $past(!done_o)) |-> ($stable(speed_front_left_o) && $stable(accel_x_o)))
    else $error("result changed without a completing word");

endmodule
